// File: sv/lrt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_pkg
// Shared widths and command codes for the racetrack LRU shift tracker.
// ----------------------------------------------------------------------------
package lrt_pkg;

  // field widths
  localparam int MODE_W  = 2;
  localparam int SET_W   = 6;
  localparam int WAY_W   = 4;
  localparam int STAMP_W = 64;
  localparam int SHIFT_W = 4;

  // command codes; the fourth code is a no-op
  localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FILL  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HIT   = 2'd2;

endpackage : lrt_pkg
`default_nettype wire

// File: sv/lrt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lrt_ram
// Simple dual-port synchronous RAM: one write and one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lrt_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 64
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];
  logic [DW-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule : lrt_ram
`default_nettype wire

// File: sv/lru_racetrack_shift_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_racetrack_shift_tracker
// Timestamp LRU victim selection plus per-set port shift tracking for a
// set-associative racetrack cache.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. in_mode picks
//   a victim query, a fill or a hit. Every command gives exactly one result
//   beat, flagged by out_valid for one cycle; the receiver cannot stall it.
//   out_shift_distance and out_shift_sum report the shift state after
//   the command; out_victim_way is the chosen way for a query, else 0.
// Sequence:
//   Fill / hit: port position RAM read, then the read-modify-write of the
//   port and, for fills and for hits with in_is_write low, the timestamp write.
//   Victim query: scans the first min(WAYS,16) ways; the timestamp RAM delivers
//   one way per cycle to a single 64-bit comparator.
//   Ignored commands (bad set or way, unused mode) are answered from idle.
// Reset:
//   After rst_n is released a clearing pass zeroes both RAMs, one timestamp
//   entry per cycle, over all SETS * 2**ceil(log2(WAYS)) entries (1024 at
//   the defaults). busy stays high until it ends.
// ----------------------------------------------------------------------------
module lru_racetrack_shift_tracker
  import lrt_pkg::*;
#(
  parameter int SETS = 64,
  parameter int WAYS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [MODE_W-1:0]  in_mode,
  input  wire logic [SET_W-1:0]   in_set_index,
  input  wire logic [WAY_W-1:0]   in_way,
  input  wire logic               in_is_write,
  output logic                    out_valid,
  output logic [WAY_W-1:0]        out_victim_way,
  output logic [SHIFT_W-1:0]      out_shift_distance,
  output logic [STAMP_W-1:0]      out_shift_sum
);

  // derived sizes
  localparam int SB       = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WB       = $clog2(WAYS);
  localparam int AW       = SB + WB;
  localparam int TS_DEPTH = SETS << WB;
  localparam int LIM      = (WAYS > 16) ? 16 : WAYS;
  localparam int CW       = $clog2(LIM + 1);
  localparam int SXW      = (SB > SET_W) ? SB : SET_W;
  localparam int WXW      = (WB > WAY_W) ? WB : WAY_W;
  localparam int QXW      = (CW > WB) ? CW : WB;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QUERY,
    ST_TOUCH
  } state_t;

  state_t              state_r;
  logic [AW-1:0]       clr_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic [STAMP_W-1:0]  sum_r;
  logic [SHIFT_W-1:0]  last_shift_r;
  logic                out_valid_r;
  logic [WAY_W-1:0]    out_victim_r;

  // command beat
  logic [SB-1:0]       set_r;
  logic [WAY_W-1:0]    way_r;
  logic                do_stamp_r;

  // query scan
  logic [CW-1:0]       rd_idx_r;
  logic                cmp_vld_r;
  logic [WAY_W-1:0]    cmp_idx_r;
  logic [STAMP_W-1:0]  best_ts_r;
  logic [WAY_W-1:0]    best_way_r;

  // RAM ports
  logic                ts_we, ts_re;
  logic [AW-1:0]       ts_waddr, ts_raddr;
  logic [STAMP_W-1:0]  ts_wdata, ts_rdata;
  logic                pt_we, pt_re;
  logic [SB-1:0]       pt_waddr, pt_raddr;
  logic [SHIFT_W-1:0]  pt_wdata, pt_rdata;

  logic                accept;
  logic                set_ok, way_ok;
  logic [SXW-1:0]      set_ext;
  logic [WXW-1:0]      way_ext;
  logic [QXW-1:0]      qidx_ext;
  logic [SHIFT_W-1:0]  shift_dist_nxt;
  logic [STAMP_W-1:0]  sum_nxt;
  logic                take;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  // range checks on the incoming beat
  assign set_ok  = {7'd0, in_set_index} < 13'(SETS);
  assign way_ok  = {2'd0, in_way} < 6'(WAYS);
  assign set_ext = SXW'(in_set_index);

  // address slices
  assign way_ext  = WXW'(way_r);
  assign qidx_ext = QXW'(rd_idx_r);

  // timestamp RAM: clear sweep, stamp write, query read
  always_comb begin
    ts_we    = (state_r == ST_CLEAR) || ((state_r == ST_TOUCH) && do_stamp_r);
    ts_waddr = (state_r == ST_CLEAR) ? clr_r : {set_r, way_ext[WB-1:0]};
    ts_wdata = (state_r == ST_CLEAR) ? '0 : stamp_r;
    ts_re    = (state_r == ST_QUERY) && (rd_idx_r != CW'(LIM));
    ts_raddr = {set_r, qidx_ext[WB-1:0]};
  end

  // port position RAM: read on accept, write back in touch, zeroed by the clear sweep
  always_comb begin
    pt_we    = (state_r == ST_CLEAR) || (state_r == ST_TOUCH);
    pt_waddr = (state_r == ST_CLEAR) ? clr_r[AW-1:WB] : set_r;
    pt_wdata = (state_r == ST_CLEAR) ? '0 : way_r;
    pt_re    = accept;
    pt_raddr = set_ext[SB-1:0];
  end

  lrt_ram #(
    .DEPTH (TS_DEPTH),
    .AW    (AW),
    .DW    (STAMP_W)
  ) u_ts_ram (
    .clk   (clk),
    .we    (ts_we),
    .waddr (ts_waddr),
    .wdata (ts_wdata),
    .re    (ts_re),
    .raddr (ts_raddr),
    .rdata (ts_rdata)
  );

  lrt_ram #(
    .DEPTH (SETS),
    .AW    (SB),
    .DW    (SHIFT_W)
  ) u_port_ram (
    .clk   (clk),
    .we    (pt_we),
    .waddr (pt_waddr),
    .wdata (pt_wdata),
    .re    (pt_re),
    .raddr (pt_raddr),
    .rdata (pt_rdata)
  );

  // shift distance from old port position to the accessed way
  always_comb begin
    shift_dist_nxt = (way_r > pt_rdata) ? (way_r - pt_rdata) : (pt_rdata - way_r);
    sum_nxt        = sum_r + {{(STAMP_W-SHIFT_W){1'b0}}, shift_dist_nxt};
  end

  // running minimum; first way seeds it, ties keep the lower way
  assign take = (cmp_idx_r == '0) || (ts_rdata < best_ts_r);

  // control FSM and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_r        <= '0;
      stamp_r      <= '0;
      sum_r        <= '0;
      last_shift_r <= '0;
      out_valid_r  <= 1'b0;
      out_victim_r <= '0;
      rd_idx_r     <= '0;
      cmp_vld_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(TS_DEPTH - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            set_r      <= set_ext[SB-1:0];
            way_r      <= in_way;
            do_stamp_r <= (in_mode == MODE_FILL) || !in_is_write;
            rd_idx_r   <= '0;
            cmp_vld_r  <= 1'b0;
            if ((in_mode == MODE_QUERY) && set_ok) begin
              state_r <= ST_QUERY;
            end else if (((in_mode == MODE_FILL) || (in_mode == MODE_HIT)) &&
                         set_ok && way_ok) begin
              state_r <= ST_TOUCH;
            end else begin
              // nothing to update: answer with current state
              out_valid_r  <= 1'b1;
              out_victim_r <= '0;
            end
          end
        end
        ST_QUERY: begin
          if (ts_re) begin
            rd_idx_r <= rd_idx_r + 1'b1;
          end
          cmp_vld_r <= ts_re;
          cmp_idx_r <= WAY_W'(rd_idx_r);
          if (cmp_vld_r) begin
            if (take) begin
              best_ts_r  <= ts_rdata;
              best_way_r <= cmp_idx_r;
            end
            if (cmp_idx_r == WAY_W'(LIM - 1)) begin
              out_valid_r  <= 1'b1;
              out_victim_r <= take ? cmp_idx_r : best_way_r;
              state_r      <= ST_IDLE;
            end
          end
        end
        ST_TOUCH: begin
          sum_r        <= sum_nxt;
          last_shift_r <= shift_dist_nxt;
          if (do_stamp_r) begin
            stamp_r <= stamp_r + 1'b1;
          end
          out_valid_r  <= 1'b1;
          out_victim_r <= '0;
          state_r      <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_victim_way     = out_victim_r;
  assign out_shift_distance = last_shift_r;
  assign out_shift_sum      = sum_r;

endmodule : lru_racetrack_shift_tracker
`default_nettype wire
